// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tdob_pkg.sv -----
package tdob_pkg;

    localparam int ROWS           = 100;
    localparam int WORDS_PER_ROW  = 10;
    localparam int TEXTURE_DEPTH  = 16384;
    localparam int TEX_AW         = $clog2(TEXTURE_DEPTH);
    localparam int ROW_W          = $clog2(ROWS);
    localparam int COL_W          = $clog2(WORDS_PER_ROW);
    localparam int WIDX_W         = 10;
    localparam int FRAME_WORDS    = ROWS * WORDS_PER_ROW;
    localparam int PAIRS_PER_WORD = 16;

    localparam logic [13:0] ADVANCE_RESET = 14'd130;
    localparam logic [1:0]  OVERLAY_RESET = 2'd1;
    localparam logic [1:0]  OVERLAY_LAST  = 2'd2;
    localparam logic [6:0]  OPACITY_MAX   = 7'd64;
    localparam logic [6:0]  DARK_BASE     = 7'd63;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_FRAME = 2'd1,
        ACT_PAIR  = 2'd2
    } action_t;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_VIDEO = 1'b1
    } kind_t;

    typedef struct packed {
        action_t     action;
        logic [13:0] texel_addr;
        logic [7:0]  texel_value;
        logic [31:0] tunnel_word;
        logic [31:0] overlay_word;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  overlay_index;
        logic [9:0]  word_index;
        logic [31:0] video_word;
    } out_item_t;

    typedef logic [5:0] bayer_row_t [8];

    localparam bayer_row_t BAYER [8] = '{
        '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
        '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
        '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
        '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
        '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
        '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
        '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
        '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
    };

    function automatic logic [5:0] bayer(input logic [2:0] row, input logic [2:0] col);
        return BAYER[row][col];
    endfunction

    // Bit i of the mask is set where the level beats the threshold of column i mod 8.
    function automatic logic [31:0] opacity_mask(input logic [6:0] level,
                                                 input logic [2:0] row);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            m[i] = level > {1'b0, BAYER[row][i % 8]};
        end
        return m;
    endfunction

endpackage

// ----- design/tdob_texel_ram.sv -----
module tdob_texel_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [tdob_pkg::TEX_AW-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_en,
    input  logic [tdob_pkg::TEX_AW-1:0] rd_addr0,
    input  logic [tdob_pkg::TEX_AW-1:0] rd_addr1,
    output logic [7:0]                rd_data0,
    output logic [7:0]                rd_data1
);

    logic [7:0] mem [tdob_pkg::TEXTURE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

// ----- design/tunnel_dither_overlay_blend_core.sv -----
// Dithered texture tunnel with fading overlay. One transaction is accepted per cycle in
// steady state: texel loads, frame starts and pixel pairs may follow each other back to
// back, and a load is seen by a pixel pair accepted in the very next cycle. Each pixel pair
// does its two texel reads in the cycle it is accepted through the two read ports of the
// texel RAM; the threshold compare follows in the next cycle, and a frame-info or finished
// video-word result is loaded from stage 1 into the output register as soon as that register
// is free or being emptied.
// s_ready drops only while a result-producing transaction waits behind an output register
// that the downstream side has not emptied. The texel RAM is not cleared at reset; load
// every texel before rendering. Write advance_step only while the block is idle.
module tunnel_dither_overlay_blend_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tdob_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tdob_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [13:0]         cfg_wr_data
);

    localparam int ROW_W = tdob_pkg::ROW_W;
    localparam int COL_W = tdob_pkg::COL_W;
    localparam int WIDX_W = tdob_pkg::WIDX_W;

    // Stage 0 state
    logic [13:0]       adv_step_reg;
    logic [13:0]       tex_off_reg, tex_off_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [3:0]        pair_reg, pair_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic [6:0]        dark_reg, dark_next;
    logic [6:0]        level_reg, level_next;
    logic              ramp_down_reg, ramp_down_next;
    logic [1:0]        choice_reg, choice_next;
    logic [6:0]        mask_level_reg, mask_level_next;
    logic [31:0]       shadow_reg [tdob_pkg::WORDS_PER_ROW];

    // Stage 1 state
    logic              s1_valid_reg;
    logic              s1_frame_reg;
    logic              s1_last_reg;
    logic [3:0]        s1_pair_reg;
    logic [6:0]        s1_thr0_reg, s1_thr1_reg;
    logic [31:0]       s1_sm_reg, s1_om_reg;
    logic [WIDX_W-1:0] s1_widx_reg;
    logic [1:0]        s1_ovl_reg;
    logic [31:0]       acc_reg;

    logic              out_valid_reg;
    tdob_pkg::out_item_t out_data_reg;

    logic accept, is_load, is_frame, is_pair, last_pair;
    logic s1_emit, s1_go;
    logic [13:0] uv0, uv1;
    logic [tdob_pkg::TEX_AW-1:0] rd_addr0, rd_addr1;
    logic [7:0] texel0, texel1;
    logic [6:0] dark_cur, thr0, thr1, dist_val;
    logic [2:0] brow;
    logic [31:0] mask, shadow_cur;
    logic [1:0] choice_shown;
    logic hit0, hit1;
    logic [31:0] acc_cur;

    assign accept   = s_valid && s_ready;
    assign is_load  = accept && (s_data.action == tdob_pkg::ACT_LOAD);
    assign is_frame = accept && (s_data.action == tdob_pkg::ACT_FRAME);
    assign is_pair  = accept && (s_data.action == tdob_pkg::ACT_PAIR);
    assign last_pair = pair_reg == 4'(tdob_pkg::PAIRS_PER_WORD - 1);

    // A transaction with a result waits in stage 1 until the output register is free.
    assign s1_emit = s1_valid_reg && (s1_frame_reg || s1_last_reg);
    assign s1_go   = !s1_emit || !out_valid_reg || m_ready;
    assign s_ready = s1_go;

    assign uv0 = s_data.tunnel_word[13:0];
    assign uv1 = s_data.tunnel_word[29:16];
    assign rd_addr0 = tdob_pkg::TEX_AW'(uv0 + tex_off_reg);
    assign rd_addr1 = tdob_pkg::TEX_AW'(uv1 + tex_off_reg);

    tdob_texel_ram u_texel_ram (
        .aclk     (aclk),
        .wr_en    (is_load),
        .wr_addr  (tdob_pkg::TEX_AW'(s_data.texel_addr)),
        .wr_data  (s_data.texel_value),
        .rd_en    (s1_go),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (texel0),
        .rd_data1 (texel1)
    );

    assign brow = row_reg[2:0];
    assign dist_val = uv0[6:0];
    assign dark_cur = (pair_reg[1:0] == 2'd0)
                    ? ((dist_val > tdob_pkg::DARK_BASE) ? 7'(dist_val - tdob_pkg::DARK_BASE)
                                                        : 7'd0)
                    : dark_reg;
    assign thr0 = {1'b0, tdob_pkg::bayer(brow, {pair_reg[1:0], 1'b0})} + dark_cur;
    assign thr1 = {1'b0, tdob_pkg::bayer(brow, {pair_reg[1:0], 1'b1})} + dark_cur;
    assign mask = tdob_pkg::opacity_mask(mask_level_reg, brow);
    assign shadow_cur = shadow_reg[col_reg];
    assign choice_shown = (choice_reg > tdob_pkg::OVERLAY_LAST) ? 2'd0 : choice_reg;

    always_comb begin
        tex_off_next    = tex_off_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pair_next       = pair_reg;
        widx_next       = widx_reg;
        dark_next       = dark_reg;
        level_next      = level_reg;
        ramp_down_next  = ramp_down_reg;
        choice_next     = choice_reg;
        mask_level_next = mask_level_reg;
        if (is_frame) begin
            mask_level_next = level_reg;
            if (level_reg > tdob_pkg::OPACITY_MAX) begin
                level_next     = tdob_pkg::OPACITY_MAX;
                ramp_down_next = 1'b1;
            end else if (level_reg == 7'd0) begin
                ramp_down_next = 1'b0;
                choice_next    = (choice_reg >= tdob_pkg::OVERLAY_LAST) ? 2'd0
                                                                         : choice_reg + 2'd1;
            end
            level_next = ramp_down_next ? level_next - 7'd1 : level_next + 7'd1;
            row_next  = '0;
            col_next  = '0;
            pair_next = '0;
            widx_next = '0;
        end else if (is_pair) begin
            dark_next = dark_cur;
            if (!last_pair) begin
                pair_next = pair_reg + 4'd1;
            end else begin
                pair_next = '0;
                if (col_reg == COL_W'(tdob_pkg::WORDS_PER_ROW - 1)) begin
                    col_next = '0;
                    if (row_reg == ROW_W'(tdob_pkg::ROWS - 1)) begin
                        row_next     = '0;
                        widx_next    = '0;
                        tex_off_next = tex_off_reg + adv_step_reg;
                    end else begin
                        row_next  = row_reg + ROW_W'(1);
                        widx_next = widx_reg + WIDX_W'(1);
                    end
                end else begin
                    col_next  = col_reg + COL_W'(1);
                    widx_next = widx_reg + WIDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adv_step_reg   <= tdob_pkg::ADVANCE_RESET;
            tex_off_reg    <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            pair_reg       <= '0;
            widx_reg       <= '0;
            dark_reg       <= '0;
            level_reg      <= '0;
            ramp_down_reg  <= 1'b0;
            choice_reg     <= tdob_pkg::OVERLAY_RESET;
            mask_level_reg <= '0;
            for (int i = 0; i < tdob_pkg::WORDS_PER_ROW; i++) begin
                shadow_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                adv_step_reg <= cfg_wr_data;
            end
            tex_off_reg    <= tex_off_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            pair_reg       <= pair_next;
            widx_reg       <= widx_next;
            dark_reg       <= dark_next;
            level_reg      <= level_next;
            ramp_down_reg  <= ramp_down_next;
            choice_reg     <= choice_next;
            mask_level_reg <= mask_level_next;
            if (is_frame) begin
                for (int i = 0; i < tdob_pkg::WORDS_PER_ROW; i++) begin
                    shadow_reg[i] <= '0;
                end
            end else if (is_pair && last_pair) begin
                shadow_reg[col_reg] <= s_data.overlay_word;
            end
        end
    end

    // Stage 1 payload, loaded together with the texel RAM read.
    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s1_frame_reg <= is_frame;
            s1_last_reg  <= last_pair;
            s1_pair_reg  <= pair_reg;
            s1_thr0_reg  <= thr0;
            s1_thr1_reg  <= thr1;
            s1_sm_reg    <= shadow_cur & mask;
            s1_om_reg    <= s_data.overlay_word & mask;
            s1_widx_reg  <= widx_reg;
            s1_ovl_reg   <= choice_shown;
        end
    end

    assign hit0 = texel0 > {1'b0, s1_thr0_reg};
    assign hit1 = texel1 > {1'b0, s1_thr1_reg};
    assign acc_cur = acc_reg | (32'(hit0) << {s1_pair_reg, 1'b0})
                             | (32'(hit1) << {s1_pair_reg, 1'b1});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_go) begin
                s1_valid_reg <= is_frame || is_pair;
            end
            if (s1_valid_reg && s1_go) begin
                acc_reg <= s1_emit ? '0 : acc_cur;
            end
            if (s1_emit && s1_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_emit && s1_go) begin
            if (s1_frame_reg) begin
                out_data_reg.kind          <= tdob_pkg::KIND_FRAME;
                out_data_reg.overlay_index <= s1_ovl_reg;
                out_data_reg.word_index    <= '0;
                out_data_reg.video_word    <= '0;
            end else begin
                out_data_reg.kind          <= tdob_pkg::KIND_VIDEO;
                out_data_reg.overlay_index <= '0;
                out_data_reg.word_index    <= s1_widx_reg;
                out_data_reg.video_word    <= (acc_cur & ~s1_sm_reg) | s1_om_reg;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- design/tdob_checker.sv -----
`include "assert_macros.svh"

module tdob_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tdob_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input tdob_pkg::out_item_t m_data
);

    `ASSERT_CLK(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_data), "input transaction dropped or changed while stalled")

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped or changed while stalled")

    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")

    `ASSERT_CLK(a_frame_fields, aclk, aresetn, m_valid && m_data.kind == tdob_pkg::KIND_FRAME |-> m_data.word_index == '0 && m_data.video_word == '0 && m_data.overlay_index != 2'd3, "malformed frame-info result")

    `ASSERT_CLK(a_video_fields, aclk, aresetn, m_valid && m_data.kind == tdob_pkg::KIND_VIDEO |-> m_data.overlay_index == 2'd0 && m_data.word_index < 10'(tdob_pkg::FRAME_WORDS), "video word outside the frame")

endmodule

bind tunnel_dither_overlay_blend_core tdob_checker u_tdob_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0]  ACT_UNUSED       = 2'd3;
    localparam logic [13:0] ADVANCE_AT_RESET = 14'd130;
    localparam logic [13:0] ADVANCE_TOP      = 14'h3fff;
    localparam logic [1:0]  LAST_OVERLAY     = 2'd2;
    localparam logic [6:0]  OPACITY_TOP      = 7'd64;
    localparam logic [6:0]  DARK_KNEE        = 7'd63;
    localparam int          GAP_MAX          = 14;
    localparam int          LONG_HOLD        = 80;
    localparam int          SWEEP_FRAMES     = 270;
    localparam int          RANDOM_HALF      = 30;
    localparam int          LOADED_TEXELS    = 128;
    localparam int          FRAME_RUN_WORDS  = 11;

    localparam int unsigned DITHER [8][8] = '{
        '{0,  32, 8,  40, 2,  34, 10, 42},
        '{48, 16, 56, 24, 50, 18, 58, 26},
        '{12, 44, 4,  36, 14, 46, 6,  38},
        '{60, 28, 52, 20, 62, 30, 54, 22},
        '{3,  35, 11, 43, 1,  33, 9,  41},
        '{51, 19, 59, 27, 49, 17, 57, 25},
        '{15, 47, 7,  39, 13, 45, 5,  37},
        '{63, 31, 55, 23, 61, 29, 53, 21}
    };

    typedef enum {PACE_STEADY, PACE_SPARSE, PACE_BURSTY} pace_t;

    class video_word_tracker;
        logic [7:0]  texels [tdob_pkg::TEXTURE_DEPTH];
        logic [31:0] shadow [tdob_pkg::WORDS_PER_ROW];
        logic [31:0] masks [8];
        logic [6:0]  level;
        logic        falling;
        logic [1:0]  overlay_sel;
        logic [13:0] offset;
        logic [13:0] advance;
        int unsigned row;
        int unsigned col;
        logic [3:0]  pair;
        logic [31:0] pixels;
        logic [6:0]  dark;
        tdob_pkg::out_item_t results_due [$];
        int unsigned errors;

        function new();
            foreach (texels[i]) texels[i] = 8'd0;
            foreach (shadow[i]) shadow[i] = '0;
            foreach (masks[i]) masks[i] = '0;
            level       = '0;
            falling     = 1'b0;
            overlay_sel = 2'd1;
            offset      = '0;
            advance     = ADVANCE_AT_RESET;
            row         = 0;
            col         = 0;
            pair        = '0;
            pixels      = '0;
            dark        = '0;
            errors      = 0;
        endfunction

        function void take_input(tdob_pkg::in_item_t it);
            tdob_pkg::out_item_t res;
            logic [15:0] uv0;
            logic [15:0] uv1;
            logic [13:0] idx0;
            logic [13:0] idx1;
            logic [2:0]  brow;
            int unsigned px;
            res = '0;
            case (it.action)
                tdob_pkg::ACT_LOAD: texels[it.texel_addr] = it.texel_value;
                tdob_pkg::ACT_FRAME: begin
                    res.kind          = tdob_pkg::KIND_FRAME;
                    res.overlay_index = overlay_sel;
                    results_due.push_back(res);
                    // Masks are built from the level before it steps.
                    for (int r = 0; r < 8; r++) begin
                        for (int i = 0; i < 32; i++) begin
                            masks[r][i] = level > DITHER[r][i % 8];
                        end
                    end
                    if (level > OPACITY_TOP) begin
                        level   = OPACITY_TOP;
                        falling = 1'b1;
                    end else if (level == 7'd0) begin
                        falling     = 1'b0;
                        overlay_sel = (overlay_sel >= LAST_OVERLAY) ? 2'd0 : overlay_sel + 2'd1;
                    end
                    level = falling ? level - 7'd1 : level + 7'd1;
                    foreach (shadow[i]) shadow[i] = '0;
                    row    = 0;
                    col    = 0;
                    pair   = '0;
                    pixels = '0;
                end
                tdob_pkg::ACT_PAIR: begin
                    uv0  = it.tunnel_word[15:0];
                    uv1  = it.tunnel_word[31:16];
                    idx0 = uv0[13:0] + offset;
                    idx1 = uv1[13:0] + offset;
                    brow = row[2:0];
                    px   = pair * 2;
                    if (pair[1:0] == 2'd0) begin
                        dark = (uv0[6:0] > DARK_KNEE) ? uv0[6:0] - DARK_KNEE : 7'd0;
                    end
                    if (texels[idx0] > DITHER[brow][px % 8] + dark) pixels[px] = 1'b1;
                    if (texels[idx1] > DITHER[brow][(px + 1) % 8] + dark) pixels[px + 1] = 1'b1;
                    if (pair != 4'd15) begin
                        pair = pair + 4'd1;
                    end else begin
                        res.kind       = tdob_pkg::KIND_VIDEO;
                        res.word_index = 10'(row * tdob_pkg::WORDS_PER_ROW + col);
                        res.video_word = (pixels & ~(shadow[col] & masks[brow]))
                                       | (it.overlay_word & masks[brow]);
                        results_due.push_back(res);
                        shadow[col] = it.overlay_word;
                        pixels      = '0;
                        pair        = '0;
                        if (col == tdob_pkg::WORDS_PER_ROW - 1) begin
                            col = 0;
                            if (row == tdob_pkg::ROWS - 1) begin
                                row    = 0;
                                offset = offset + advance;
                            end else begin
                                row++;
                            end
                        end else begin
                            col++;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_output(tdob_pkg::out_item_t got);
            tdob_pkg::out_item_t want;
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                want = results_due.pop_front();
                compare("kind", want.kind, got.kind);
                compare("overlay_index", want.overlay_index, got.overlay_index);
                compare("word_index", want.word_index, got.word_index);
                compare("video_word", want.video_word, got.video_word);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    tdob_pkg::in_item_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    tdob_pkg::out_item_t m_data;
    logic                cfg_wr_en   = 1'b0;
    logic [13:0]         cfg_wr_data = '0;

    video_word_tracker tracker = new();
    pace_t             pace = PACE_STEADY;
    bit                hold_output = 1'b0;

    tunnel_dither_overlay_blend_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tunnel_dither_overlay_blend_core regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_output(m_data);
        end
    end

    function automatic int draw_gap();
        case (pace)
            PACE_SPARSE: return ($urandom_range(0, 31) == 0) ? $urandom_range(0, GAP_MAX) : 0;
            PACE_BURSTY: return $urandom_range(0, GAP_MAX);
            default:     return 0;
        endcase
    endfunction

    function automatic tdob_pkg::in_item_t make_item(input logic [1:0] act);
        logic [95:0]        raw;
        tdob_pkg::in_item_t it;
        raw       = {$urandom, $urandom, $urandom};
        it        = raw[87:0];
        it.action = tdob_pkg::action_t'(act);
        return it;
    endfunction

    // Coordinates stay inside the loaded corner of the texel store.
    function automatic tdob_pkg::in_item_t make_pair();
        tdob_pkg::in_item_t it;
        it = make_item(tdob_pkg::ACT_PAIR);
        it.tunnel_word[13:7]  = '0;
        it.tunnel_word[29:23] = '0;
        return it;
    endfunction

    task automatic send(input tdob_pkg::in_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        tracker.take_input(it);
    endtask

    // Waits out every outstanding result plus the pipeline behind the last transaction.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_advance(input logic [13:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.advance = value;
    endtask

    task automatic render_words(input int count);
        repeat (count * tdob_pkg::PAIRS_PER_WORD) send(make_pair());
    endtask

    task automatic random_traffic(input int count);
        int counted;
        int pick;
        counted = 0;
        while (counted < count) begin
            if (counted % 50 == 0) begin
                pace = ($urandom_range(0, 3) == 0) ? PACE_STEADY : PACE_BURSTY;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send(make_item(tdob_pkg::ACT_FRAME));
            end else if (pick < 8) begin
                send(make_item(tdob_pkg::ACT_LOAD));
            end else if (pick < 10) begin
                send(make_item(ACT_UNUSED));
                counted--;
            end else begin
                send(make_pair());
            end
            counted++;
        end
    endtask

    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        tdob_pkg::in_item_t it;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_advance(ADVANCE_TOP);

        // Pixel pairs only read this corner of the store and its top entry.
        for (int a = 0; a < LOADED_TEXELS; a++) begin
            it = make_item(tdob_pkg::ACT_LOAD);
            it.texel_addr = 14'(a);
            send(it);
        end

        pace = PACE_BURSTY;
        it = make_item(tdob_pkg::ACT_LOAD);
        it.texel_addr  = 14'h3fff;
        it.texel_value = 8'hff;
        send(it);
        it = make_item(tdob_pkg::ACT_LOAD);
        it.texel_addr  = '0;
        it.texel_value = '0;
        send(it);
        send(make_item(tdob_pkg::ACT_FRAME));
        for (int p = 0; p < tdob_pkg::PAIRS_PER_WORD; p++) begin
            it = make_pair();
            // Full distance gives the deepest darkening; 63 and 64 sit on the knee.
            if (p == 0) it.tunnel_word = '1;
            if (p == 1) it.tunnel_word = '0;
            if (p == 4) it.tunnel_word[6:0] = 7'd63;
            if (p == 8) it.tunnel_word[6:0] = 7'd64;
            if (p == tdob_pkg::PAIRS_PER_WORD - 1) it.overlay_word = '1;
            send(it);
        end
        send(make_item(ACT_UNUSED));
        send(make_item(tdob_pkg::ACT_FRAME));

        // Enough frame starts for the opacity to ramp up and down and the overlay to wrap.
        pace = PACE_SPARSE;
        repeat (SWEEP_FRAMES) begin
            send(make_item(tdob_pkg::ACT_FRAME));
            if ($urandom_range(0, 63) == 0) render_words(1);
        end
        drain();
        write_advance(14'($urandom_range(1, 16382)));

        // More than one row of a frame, so shadows and the masks of two rows are used.
        send(make_item(tdob_pkg::ACT_FRAME));
        render_words(FRAME_RUN_WORDS);

        random_traffic(RANDOM_HALF);

        // Output held off while frame starts keep coming, so the input side backs up.
        pace = PACE_STEADY;
        hold_output = 1'b1;
        repeat (12) send(make_item(tdob_pkg::ACT_FRAME));
        drain();

        random_traffic(RANDOM_HALF);

        drain();
        if (tracker.errors == 0) begin
            $display("tunnel_dither_overlay_blend_core regression: pass");
        end else begin
            $display("tunnel_dither_overlay_blend_core regression: fail");
        end
        $finish;
    end

endmodule
